// File: rtl/rpr_pkg.sv
// Package for the residual particle resampler: field widths, transaction
// structs and the sequencer state type. No dependencies.
package rpr_pkg;

	localparam int FRAC_BITS         = 16;
	localparam int MAX_PARTICLES_DEF = 64;
	localparam int WEIGHT_W          = FRAC_BITS + 1;
	localparam int DRAW_W            = FRAC_BITS;
	localparam int INDEX_W           = 7;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [DRAW_W-1:0]   uniform_draw;
		logic                is_last;
	} rpr_item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] particle_index;
		logic               last_out;
	} rpr_result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_W_RD,
		ST_W_MUL,
		ST_W_ACC,
		ST_EMIT,
		ST_D_RD,
		ST_D_MUL,
		ST_D_TGT,
		ST_S_RD,
		ST_S_CMP
	} rpr_state_t;

endpackage

// File: rtl/rpr_mul.sv
// Shared multiplier with a registered product.
// Depends on nothing but its parameters.
module rpr_mul #(
	parameter int AW = 23,
	parameter int BW = 17
) (
	input  logic            clk,
	input  logic [AW-1:0]   a,
	input  logic [BW-1:0]   b,
	output logic [AW+BW-1:0] prod_q
);

	// Register the product for the next sequencer step
	always_ff @(posedge clk) begin
		prod_q <= (AW+BW)'(a) * (AW+BW)'(b);
	end

endmodule

// File: rtl/residual_particle_resampler_unit.sv
// Top level of the residual particle resampler: sequencer, stores, output
// register. Depends on rpr_pkg and rpr_mul.
//
// Channel | Direction | Handshake                 | Payload
// item    | in        | start & !busy             | rpr_item_t
// result  | out       | result_valid, one cycle   | rpr_result_t
//
// Loading accepts one item per cycle while not busy. On the closing item the
// block stays busy for the run: per particle a weight read, a multiply and an
// accumulate plus one emission per deterministic copy, then for each random
// slot a draw read, a multiply and a binary search of the prefix store (at
// most ceil(log2 N) probes), or a direct spread when the total residual is
// zero; the steps follow from the single multiplier and the registered read port.
// Reset clears the sequencer, counters and the output strobe.
// Results cannot be stalled; each is shown for one cycle.
module residual_particle_resampler_unit
	import rpr_pkg::*;
#(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  rpr_item_t   item,
	output logic        result_valid,
	output rpr_result_t result
);

	localparam int IW = $clog2(MAX_PARTICLES);
	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int PW = FRAC_BITS + CW;
	localparam int MW = PW + WEIGHT_W;

	rpr_state_t state_q, state_d;
	logic [CW-1:0]   count_q, count_d, n_q, n_d, filled_q, filled_d;
	logic [IW-1:0]   i_q, i_d, draw_idx_q, draw_idx_d;
	logic [IW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
	logic [CW:0]     copies_q, copies_d;
	logic [PW-1:0]   total_q, total_d;
	logic [PW+FRAC_BITS-1:0] target_q, target_d;

	logic [WEIGHT_W-1:0] weight_mem [MAX_PARTICLES];
	logic [DRAW_W-1:0]   draw_mem [MAX_PARTICLES];
	logic [PW-1:0]       pref_mem [MAX_PARTICLES];
	logic [WEIGHT_W-1:0] w_rd_q;
	logic [DRAW_W-1:0]   d_rd_q;
	logic [PW-1:0]       p_rd_q;
	logic [IW-1:0]       rd_addr;

	logic                load_en, pref_we;
	logic [PW-1:0]       pref_wdata;
	logic [PW-1:0]       mul_a;
	logic [WEIGHT_W-1:0] mul_b;
	logic [MW-1:0]       prod_q;
	logic                emit_en;
	logic [IW:0]         emit_num;
	logic [IW:0]         mid_sum;
	logic [CW-1:0]       q_val;
	rpr_result_t         result_q;
	logic                valid_q;

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = valid_q;
	assign result       = result_q;
	assign load_en      = start && !busy;
	assign mid_sum      = (IW+1)'(lo_q) + (IW+1)'(hi_q);
	assign q_val        = prod_q[FRAC_BITS +: CW];

	rpr_mul #(.AW(PW), .BW(WEIGHT_W)) u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// Write stores on load and prefix build; read all at one address
	always_ff @(posedge clk) begin
		if (load_en) begin
			weight_mem[count_q[IW-1:0]] <= item.weight;
			draw_mem[count_q[IW-1:0]]   <= item.uniform_draw;
		end
		if (pref_we)
			pref_mem[i_q] <= pref_wdata;
		w_rd_q <= weight_mem[rd_addr];
		d_rd_q <= draw_mem[rd_addr];
		p_rd_q <= pref_mem[rd_addr];
	end

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			filled_q <= '0;
			valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			filled_q <= filled_d;
			valid_q  <= emit_en;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		n_q        <= n_d;
		i_q        <= i_d;
		draw_idx_q <= draw_idx_d;
		lo_q       <= lo_d;
		hi_q       <= hi_d;
		mid_q      <= mid_d;
		copies_q   <= copies_d;
		total_q    <= total_d;
		target_q   <= target_d;
		if (emit_en) begin
			result_q.particle_index <= INDEX_W'(emit_num) ;
			result_q.last_out       <= ((filled_q + CW'(1)) == n_q);
		end
	end

	// Sequencer: next state, unit operands, emission
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		n_d        = n_q;
		filled_d   = filled_q;
		i_d        = i_q;
		draw_idx_d = draw_idx_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		mid_d      = mid_q;
		copies_d   = copies_q;
		total_d    = total_q;
		target_d   = target_q;
		rd_addr    = i_q;
		pref_we    = 1'b0;
		pref_wdata = total_q + PW'(prod_q[FRAC_BITS-1:0]);
		mul_a      = '0;
		mul_b      = '0;
		emit_en    = 1'b0;
		emit_num   = (IW+1)'(i_q) + (IW+1)'(1);
		case (state_q)
			ST_IDLE: begin
				if (load_en) begin
					count_d = count_q + CW'(1);
					if (item.is_last || (count_q + CW'(1)) == CW'(MAX_PARTICLES)) begin
						n_d        = count_q + CW'(1);
						count_d    = '0;
						filled_d   = '0;
						i_d        = '0;
						draw_idx_d = '0;
						total_d    = '0;
						state_d    = ST_W_RD;
					end
				end
			end
			ST_W_RD: begin
				rd_addr = i_q;
				state_d = ST_W_MUL;
			end
			ST_W_MUL: begin
				mul_a   = PW'(n_q);
				mul_b   = w_rd_q;
				state_d = ST_W_ACC;
			end
			ST_W_ACC: begin
				copies_d = prod_q[FRAC_BITS +: CW+1];
				total_d  = pref_wdata;
				pref_we  = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				// Hand out deterministic copies of particle i
				if (filled_q == n_q) begin
					state_d = ST_IDLE;
				end else if (copies_q != '0) begin
					emit_en  = 1'b1;
					filled_d = filled_q + CW'(1);
					copies_d = copies_q - (CW+1)'(1);
				end else if (CW'(i_q) == n_q - CW'(1)) begin
					state_d = ST_D_RD;
				end else begin
					i_d     = i_q + IW'(1);
					state_d = ST_W_RD;
				end
			end
			ST_D_RD: begin
				rd_addr = draw_idx_q;
				state_d = (filled_q == n_q) ? ST_IDLE : ST_D_MUL;
			end
			ST_D_MUL: begin
				mul_a   = (total_q == '0) ? PW'(n_q) : total_q;
				mul_b   = WEIGHT_W'(d_rd_q);
				state_d = ST_D_TGT;
			end
			ST_D_TGT: begin
				if (total_q == '0) begin
					// No residual mass: spread by the draw, clamp to N
					emit_en    = 1'b1;
					emit_num   = (q_val > n_q - CW'(1)) ? (IW+1)'(n_q)
						: (IW+1)'(q_val) + (IW+1)'(1);
					filled_d   = filled_q + CW'(1);
					draw_idx_d = draw_idx_q + IW'(1);
					state_d    = ST_D_RD;
				end else begin
					target_d = prod_q[PW+FRAC_BITS-1:0];
					lo_d     = '0;
					hi_d     = IW'(n_q - CW'(1));
					state_d  = ST_S_RD;
				end
			end
			ST_S_RD: begin
				if (lo_q < hi_q) begin
					mid_d   = mid_sum[IW:1];
					rd_addr = mid_sum[IW:1];
					state_d = ST_S_CMP;
				end else begin
					emit_en    = 1'b1;
					emit_num   = (IW+1)'(lo_q) + (IW+1)'(1);
					filled_d   = filled_q + CW'(1);
					draw_idx_d = draw_idx_q + IW'(1);
					state_d    = ST_D_RD;
				end
			end
			ST_S_CMP: begin
				// Narrow the search window on the scaled prefix
				if ({p_rd_q, FRAC_BITS'(0)} < target_q)
					lo_d = mid_q + IW'(1);
				else
					hi_d = mid_q;
				state_d = ST_S_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> filled_q <= n_q) else $error("emitted more than N");
	a_index_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.particle_index != '0) else $error("zero index");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CW'(MAX_PARTICLES)) else $error("load count overflow");
	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result while idle");

endmodule
